/* hdl/kmp_pkg.sv */
// Shared types and constants for the KMP stream matcher.
// Depends on nothing; imported by the sequencer and the top level.
package kmp_pkg;

  localparam int unsigned CMD_BITS      = 2;
  localparam int unsigned SYM_PORT_BITS = 8;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_TEXT    = 2'd3
  } kmp_cmd_e;

  typedef struct packed {
    logic match;
    logic error;
  } kmp_result_t;

endpackage

/* hdl/kmp_ram.sv */
// Simple dual-port memory: one write port and one read port with registered read data.
// No dependencies; used for the pattern store and the failure table.
module kmp_ram #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 1,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/kmp_seq.sv */
// Sequencer of the KMP matcher: command decode, the shared symbol comparator,
// failure-table fallback and the output register. Depends on kmp_pkg and drives two kmp_ram.
module kmp_seq #(
  parameter int unsigned PATTERN_DEPTH = 4096,
  parameter int unsigned SYMBOL_BITS   = 8,
  localparam int unsigned IW = $clog2(PATTERN_DEPTH),
  localparam int unsigned LW = $clog2(PATTERN_DEPTH + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  kmp_pkg::kmp_cmd_e                    command_i,
  input  logic [kmp_pkg::SYM_PORT_BITS-1:0]    symbol_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output kmp_pkg::kmp_result_t                 result_o,
  output logic                                 pat_we_o,
  output logic [IW-1:0]                        pat_waddr_o,
  output logic [SYMBOL_BITS-1:0]               pat_wdata_o,
  output logic [IW-1:0]                        pat_raddr_o,
  input  logic [SYMBOL_BITS-1:0]               pat_rdata_i,
  output logic                                 fail_we_o,
  output logic [IW-1:0]                        fail_waddr_o,
  output logic [IW-1:0]                        fail_wdata_o,
  output logic [IW-1:0]                        fail_raddr_o,
  input  logic [IW-1:0]                        fail_rdata_i
);
  import kmp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRD,
    S_PCMP,
    S_FWAIT,
    S_FMATCH,
    S_RESP
  } state_e;

  state_e           state_q;
  kmp_cmd_e         cmd_q;
  logic [SYMBOL_BITS-1:0] sym_q;
  logic [LW-1:0]    len_q;
  logic [IW-1:0]    bpos_q;
  logic [LW-1:0]    mpos_q;
  logic [LW-1:0]    j_q;
  kmp_result_t      res_q;
  kmp_result_t      out_res_q;
  logic             out_valid_q;

  logic [SYMBOL_BITS-1:0] sym_in;
  logic             full;
  logic             accept;
  logic             eq;
  logic             fallback;
  logic [LW-1:0]    jn;
  logic [LW-1:0]    jm1;
  logic [LW-1:0]    lm1;

  assign sym_in   = SYMBOL_BITS'(symbol_i);
  assign full     = (len_q == LW'(PATTERN_DEPTH));
  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign eq       = (pat_rdata_i == sym_q);
  assign jn       = j_q + LW'(eq);
  assign jm1      = j_q - LW'(1);
  assign lm1      = len_q - LW'(1);
  assign fallback = (state_q == S_PCMP) && (j_q != '0) && !eq;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_o    = out_res_q;

  always_comb begin
    pat_we_o     = accept && (command_i == CMD_APPEND) && !full;
    pat_waddr_o  = len_q[IW-1:0];
    pat_wdata_o  = sym_in;
    pat_raddr_o  = j_q[IW-1:0];
    fail_we_o    = (pat_we_o && (len_q == '0))
                   || ((state_q == S_PCMP) && !fallback && (cmd_q == CMD_APPEND));
    fail_waddr_o = len_q[IW-1:0];
    fail_wdata_o = (state_q == S_PCMP) ? jn[IW-1:0] : '0;
    fail_raddr_o = fallback ? jm1[IW-1:0] : lm1[IW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= CMD_CLEAR;
      sym_q       <= '0;
      len_q       <= '0;
      bpos_q      <= '0;
      mpos_q      <= '0;
      j_q         <= '0;
      res_q       <= '0;
      out_res_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q <= command_i;
            sym_q <= sym_in;
            case (command_i)
              CMD_CLEAR: begin
                len_q   <= '0;
                bpos_q  <= '0;
                mpos_q  <= '0;
                res_q   <= '0;
                state_q <= S_RESP;
              end
              CMD_APPEND: begin
                res_q <= '{match: 1'b0, error: full};
                if (full) begin
                  state_q <= S_RESP;
                end else if (len_q == '0) begin
                  bpos_q  <= '0;
                  len_q   <= LW'(1);
                  state_q <= S_RESP;
                end else begin
                  j_q     <= LW'(bpos_q);
                  state_q <= S_PRD;
                end
              end
              CMD_RESTART: begin
                mpos_q  <= '0;
                res_q   <= '0;
                state_q <= S_RESP;
              end
              CMD_TEXT: begin
                res_q <= '{match: (len_q == '0), error: 1'b0};
                if (len_q == '0) begin
                  state_q <= S_RESP;
                end else begin
                  j_q     <= (mpos_q >= len_q) ? '0 : mpos_q;
                  state_q <= S_PRD;
                end
              end
              default: begin
                res_q   <= '0;
                state_q <= S_RESP;
              end
            endcase
          end
        end
        S_PRD: begin
          state_q <= S_PCMP;
        end
        S_PCMP: begin
          if (fallback) begin
            state_q <= S_FWAIT;
          end else if (cmd_q == CMD_APPEND) begin
            bpos_q  <= jn[IW-1:0];
            len_q   <= len_q + LW'(1);
            state_q <= S_RESP;
          end else if (jn == len_q) begin
            res_q.match <= 1'b1;
            state_q     <= S_FMATCH;
          end else begin
            mpos_q  <= jn;
            state_q <= S_RESP;
          end
        end
        S_FWAIT: begin
          j_q     <= LW'(fail_rdata_i);
          state_q <= S_PRD;
        end
        S_FMATCH: begin
          mpos_q  <= LW'(fail_rdata_i);
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_res_q   <= res_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_mpos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mpos_q < len_q) || (mpos_q == '0))
    else $error("Text position is outside the pattern.");

  a_bpos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (LW'(bpos_q) < len_q) || (bpos_q == '0))
    else $error("Build position is outside the pattern.");

  a_cmp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PCMP) |-> (j_q < len_q))
    else $error("Compare index is outside the pattern.");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_res_q.match && out_res_q.error))
    else $error("Match and error are flagged in one transaction.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("Input not stalled after an accepted transaction.");

endmodule

/* hdl/kmp_stream_matcher_top.sv */
// Top level of the KMP stream matcher: sequencer plus pattern and failure-table memories.
// Depends on kmp_pkg, kmp_ram and kmp_seq.
// Clear, restart, overflowing or first append, and text on an empty pattern need no memory read.
// Other appends and text transactions read the pattern and compare; each failure-table fallback
// adds a failure-table read, a pattern read and a compare, and a match adds a failure-table read.
// One transaction is in flight at a time; fallbacks average at most one per symbol.
// Reset clears the lengths and positions; the memories are not cleared and need no sweep.
module kmp_stream_matcher_top #(
  parameter int unsigned PATTERN_DEPTH = 4096,
  parameter int unsigned SYMBOL_BITS   = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [7:0] symbol_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       match_o,
  output logic       error_o
);
  import kmp_pkg::*;

  localparam int unsigned IW = $clog2(PATTERN_DEPTH);

  kmp_result_t            result;
  logic                   pat_we;
  logic [IW-1:0]          pat_waddr;
  logic [SYMBOL_BITS-1:0] pat_wdata;
  logic [IW-1:0]          pat_raddr;
  logic [SYMBOL_BITS-1:0] pat_rdata;
  logic                   fail_we;
  logic [IW-1:0]          fail_waddr;
  logic [IW-1:0]          fail_wdata;
  logic [IW-1:0]          fail_raddr;
  logic [IW-1:0]          fail_rdata;

  kmp_seq #(
    .PATTERN_DEPTH(PATTERN_DEPTH),
    .SYMBOL_BITS  (SYMBOL_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (kmp_cmd_e'(command_i)),
    .symbol_i    (symbol_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result),
    .pat_we_o    (pat_we),
    .pat_waddr_o (pat_waddr),
    .pat_wdata_o (pat_wdata),
    .pat_raddr_o (pat_raddr),
    .pat_rdata_i (pat_rdata),
    .fail_we_o   (fail_we),
    .fail_waddr_o(fail_waddr),
    .fail_wdata_o(fail_wdata),
    .fail_raddr_o(fail_raddr),
    .fail_rdata_i(fail_rdata)
  );

  kmp_ram #(
    .DEPTH(PATTERN_DEPTH),
    .WIDTH(SYMBOL_BITS)
  ) u_pattern_ram (
    .clk_i  (clk_i),
    .we_i   (pat_we),
    .waddr_i(pat_waddr),
    .wdata_i(pat_wdata),
    .raddr_i(pat_raddr),
    .rdata_o(pat_rdata)
  );

  kmp_ram #(
    .DEPTH(PATTERN_DEPTH),
    .WIDTH(IW)
  ) u_failure_ram (
    .clk_i  (clk_i),
    .we_i   (fail_we),
    .waddr_i(fail_waddr),
    .wdata_i(fail_wdata),
    .raddr_i(fail_raddr),
    .rdata_o(fail_rdata)
  );

  assign match_o = result.match;
  assign error_o = result.error;

endmodule
